FILE: design/afad_pkg.sv
// Shared types and constants of the alpha-fit area downscaler.
package afad_pkg;

  // Input command codes
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_EMIT   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_BOX_X    = 3'd0;
  localparam logic [2:0] REG_BOX_Y    = 3'd1;
  localparam logic [2:0] REG_BOX_W    = 3'd2;
  localparam logic [2:0] REG_BOX_H    = 3'd3;
  localparam logic [2:0] REG_PRESSED  = 3'd4;
  localparam logic [2:0] REG_DIM_GAIN = 3'd5;

  // Configuration reset values
  localparam logic [8:0] BOX_X_RST    = 9'd13;
  localparam logic [8:0] BOX_Y_RST    = 9'd15;
  localparam logic [8:0] BOX_W_RST    = 9'd38;
  localparam logic [8:0] BOX_H_RST    = 9'd40;
  localparam logic [8:0] DIM_GAIN_RST = 9'd159;
  localparam logic [8:0] UNITY_GAIN   = 9'd256;

  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_CAPTURE    = 4'd1,
    OP_LOAD       = 4'd2,
    OP_RES_ZERO   = 4'd3,
    OP_FIT_EMPTY  = 4'd4,
    OP_FIT_PREP   = 4'd5,
    OP_DIV_START  = 4'd6,
    OP_DIV_STORE  = 4'd7,
    OP_FIT_END    = 4'd8,
    OP_WIN_FIX    = 4'd9,
    OP_SCAN_INIT  = 4'd10,
    OP_SCAN       = 4'd11,
    OP_SHADE_PREP = 4'd12,
    OP_RES_EMIT   = 4'd13,
    OP_PUSH       = 4'd14
  } afad_op_t;

  // Which quotient a divider run produces
  typedef enum logic [3:0] {
    DV_FIT = 4'd0,
    DV_Y0  = 4'd1,
    DV_Y1  = 4'd2,
    DV_X0  = 4'd3,
    DV_X1  = 4'd4,
    DV_R   = 4'd5,
    DV_G   = 4'd6,
    DV_B   = 4'd7,
    DV_A   = 4'd8
  } afad_dsel_t;

  typedef struct packed {
    afad_op_t   op;
    afad_dsel_t dsel;
  } afad_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       ink_empty;
    logic       emit_skip;
    logic       div_done;
    logic       scan_last;
    logic       asum_zero;
    logic       out_free;
  } afad_stat_t;

endpackage

FILE: design/afad_div.sv
// Restoring divider, one quotient bit per cycle.
module afad_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
      cnt_r <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= rem_sub[DEN_W-1:0];
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: design/afad_datapath.sv
// Datapath: configuration, pixel store, ink box, fit, window sums, divider and result register.
module afad_datapath #(
  parameter int CELL_SIZE = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [8:0]         cfg_wdata,
  input  logic [63:0]        in_tdata,
  input  logic [1:0]         in_tuser,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [71:0]        out_tdata,
  output logic [1:0]         out_tuser,
  input  afad_pkg::afad_cmd_t  cmd,
  output afad_pkg::afad_stat_t stat
);
  import afad_pkg::*;

  localparam int DEPTH = CELL_SIZE * CELL_SIZE;
  localparam int CW    = $clog2(CELL_SIZE + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = 2 * CW + 1;
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int AS_W  = NW + 8;
  localparam int CA_W  = NW + 16;
  localparam int NUM_W = NW + 25;
  localparam int DEN_W = NW + 16;
  localparam int FN_W  = CW + 11;
  localparam int WN_W  = CW + 10;

  // configuration
  logic [8:0] box_x_r, box_y_r, box_w_r, box_h_r, dim_gain_r;
  logic       pressed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r    <= BOX_X_RST;
      box_y_r    <= BOX_Y_RST;
      box_w_r    <= BOX_W_RST;
      box_h_r    <= BOX_H_RST;
      pressed_r  <= 1'b0;
      dim_gain_r <= DIM_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_BOX_X:    box_x_r    <= cfg_wdata;
        REG_BOX_Y:    box_y_r    <= cfg_wdata;
        REG_BOX_W:    box_w_r    <= cfg_wdata;
        REG_BOX_H:    box_h_r    <= cfg_wdata;
        REG_PRESSED:  pressed_r  <= cfg_wdata[0];
        REG_DIM_GAIN: dim_gain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // captured item
  logic [1:0]  cmd_r;
  logic [6:0]  srcx_r, srcy_r;
  logic [31:0] pix_r;
  logic [8:0]  col_r, row_r;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE) begin
      cmd_r  <= in_tuser;
      srcx_r <= in_tdata[6:0];
      srcy_r <= in_tdata[13:7];
      pix_r  <= in_tdata[45:14];
      col_r  <= in_tdata[54:46];
      row_r  <= in_tdata[63:55];
    end
  end

  // ink box
  logic [CW-1:0] min_x_r, min_y_r, end_x_r, end_y_r;
  logic [CW-1:0] ld_x, ld_y, sw, sh;
  logic          ld_ok, ink_empty;

  assign ld_ok     = ((CW+1)'(srcx_r) < (CW+1)'(CELL_SIZE))
                     && ((CW+1)'(srcy_r) < (CW+1)'(CELL_SIZE));
  assign ld_x      = CW'(srcx_r);
  assign ld_y      = CW'(srcy_r);
  assign ink_empty = (end_x_r <= min_x_r) || (end_y_r <= min_y_r);
  assign sw        = end_x_r - min_x_r;
  assign sh        = end_y_r - min_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= CW'(CELL_SIZE);
      min_y_r <= CW'(CELL_SIZE);
      end_x_r <= '0;
      end_y_r <= '0;
    end else if (cmd.op == OP_LOAD && ld_ok && pix_r[31:24] != 8'd0) begin
      if (ld_x < min_x_r) min_x_r <= ld_x;
      if (ld_y < min_y_r) min_y_r <= ld_y;
      if (ld_x + CW'(1) > end_x_r) end_x_r <= ld_x + CW'(1);
      if (ld_y + CW'(1) > end_y_r) end_y_r <= ld_y + CW'(1);
    end
  end

  // pixel store
  logic [31:0]    mem [DEPTH];
  logic [31:0]    rd_data_r;
  logic [LW-1:0]  wr_lin, rd_lin;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic           wr_en, rd_en;
  logic [CW:0]    rpx, rpy;
  logic [CW-1:0]  scx_r, scy_r;

  assign wr_lin  = LW'(ld_y) * LW'(CELL_SIZE) + LW'(ld_x);
  assign wr_addr = wr_lin[AW-1:0];
  assign wr_en   = (cmd.op == OP_LOAD) && ld_ok;
  assign rpx     = (CW+1)'(min_x_r) + (CW+1)'(scx_r);
  assign rpy     = (CW+1)'(min_y_r) + (CW+1)'(scy_r);
  assign rd_lin  = LW'(rpy) * LW'(CELL_SIZE) + LW'(rpx);
  assign rd_addr = rd_lin[AW-1:0];
  assign rd_en   = (cmd.op == OP_SCAN) && (rpx < (CW+1)'(CELL_SIZE))
                   && (rpy < (CW+1)'(CELL_SIZE));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= pix_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // fitted size
  logic [8:0]      fit_w_r, fit_h_r, fit_q_r;
  logic            fit_wide_r;
  logic [FN_W-1:0] fit_num_r;
  logic [CW:0]     fit_den_r;
  logic [CW+8:0]   p_ws, p_hw;

  assign p_ws = (CW+9)'(box_w_r) * (CW+9)'(sh);
  assign p_hw = (CW+9)'(box_h_r) * (CW+9)'(sw);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIT_PREP) begin
      fit_wide_r <= p_ws <= p_hw;
      if (p_ws <= p_hw) begin
        fit_num_r <= (FN_W'(p_ws) << 1) + FN_W'(sw);
        fit_den_r <= {sw, 1'b0};
      end else begin
        fit_num_r <= (FN_W'(p_hw) << 1) + FN_W'(sh);
        fit_den_r <= {sh, 1'b0};
      end
    end
  end

  // divider
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [WN_W-1:0]  row_n, row1_n, col_n, col1_n;
  logic [CA_W-1:0]  acc_r_r, acc_g_r, acc_b_r;
  logic [AS_W-1:0]  acc_a_r;
  logic [NW-1:0]    n_r;
  logic [NUM_W-1:0] prod_r_r, prod_g_r, prod_b_r;

  assign row_n  = WN_W'(sh) * WN_W'(row_r);
  assign row1_n = WN_W'(sh) * (WN_W'(row_r) + WN_W'(1));
  assign col_n  = WN_W'(sw) * WN_W'(col_r);
  assign col1_n = WN_W'(sw) * (WN_W'(col_r) + WN_W'(1));

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (cmd.dsel)
      DV_FIT: begin div_num = NUM_W'(fit_num_r); div_den = DEN_W'(fit_den_r); end
      DV_Y0:  begin div_num = NUM_W'(row_n);     div_den = DEN_W'(fit_h_r);   end
      DV_Y1:  begin div_num = NUM_W'(row1_n);    div_den = DEN_W'(fit_h_r);   end
      DV_X0:  begin div_num = NUM_W'(col_n);     div_den = DEN_W'(fit_w_r);   end
      DV_X1:  begin div_num = NUM_W'(col1_n);    div_den = DEN_W'(fit_w_r);   end
      DV_R:   begin div_num = prod_r_r; div_den = DEN_W'(acc_a_r) << 8; end
      DV_G:   begin div_num = prod_g_r; div_den = DEN_W'(acc_a_r) << 8; end
      DV_B:   begin div_num = prod_b_r; div_den = DEN_W'(acc_a_r) << 8; end
      DV_A:   begin div_num = NUM_W'(acc_a_r); div_den = DEN_W'(n_r); end
      default: ;
    endcase
  end

  afad_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_DIV_START),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // clamp colour quotients at full scale
  logic [7:0] q_sat;
  assign q_sat = (div_quo[NUM_W-1:8] != '0) ? 8'hFF : div_quo[7:0];

  logic [CW-1:0] y0_r, y1_r, x0_r, x1_r;
  logic [7:0]    res_red_r, res_green_r, res_blue_r, res_alpha_r;

  // result staging
  logic       res_written_r, res_empty_r;
  logic [9:0] res_dx_r, res_dy_r;
  logic [8:0] res_fw_r, res_fh_r;
  logic [8:0] bw1, bh1, off_x, off_y;
  logic [10:0] lx, ly;

  assign bw1   = (box_w_r == 9'd0) ? 9'd1 : box_w_r;
  assign bh1   = (box_h_r == 9'd0) ? 9'd1 : box_h_r;
  assign off_x = (box_w_r >= fit_w_r) ? ((box_w_r - fit_w_r) >> 1) : 9'd0;
  assign off_y = (box_h_r >= fit_h_r) ? ((box_h_r - fit_h_r) >> 1) : 9'd0;
  assign lx    = 11'(box_x_r) + 11'(off_x) + 11'(col_r);
  assign ly    = 11'(box_y_r) + 11'(off_y) + 11'(row_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_w_r <= '0;
      fit_h_r <= '0;
    end else if (cmd.op == OP_FIT_EMPTY) begin
      fit_w_r <= '0;
      fit_h_r <= '0;
    end else if (cmd.op == OP_FIT_END) begin
      fit_w_r <= fit_wide_r ? bw1 : fit_q_r;
      fit_h_r <= fit_wide_r ? fit_q_r : bh1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_DIV_STORE: begin
        case (cmd.dsel)
          DV_FIT: fit_q_r <= (div_quo == '0) ? 9'd1 : div_quo[8:0];
          DV_Y0:  y0_r <= div_quo[CW-1:0];
          DV_Y1:  y1_r <= div_quo[CW-1:0];
          DV_X0:  x0_r <= div_quo[CW-1:0];
          DV_X1:  x1_r <= div_quo[CW-1:0];
          DV_R:   res_red_r   <= q_sat;
          DV_G:   res_green_r <= q_sat;
          DV_B:   res_blue_r  <= q_sat;
          DV_A:   res_alpha_r <= div_quo[7:0];
          default: ;
        endcase
      end
      OP_WIN_FIX: begin
        // a window is at least one pixel on each axis
        if (y1_r <= y0_r) y1_r <= y0_r + CW'(1);
        if (x1_r <= x0_r) x1_r <= x0_r + CW'(1);
      end
      OP_RES_ZERO, OP_FIT_EMPTY, OP_FIT_END: begin
        res_red_r   <= '0;
        res_green_r <= '0;
        res_blue_r  <= '0;
        res_alpha_r <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_RES_ZERO: begin
        res_written_r <= 1'b0;
        res_empty_r   <= 1'b0;
        res_dx_r      <= '0;
        res_dy_r      <= '0;
        res_fw_r      <= '0;
        res_fh_r      <= '0;
      end
      OP_FIT_EMPTY: begin
        res_written_r <= 1'b0;
        res_empty_r   <= 1'b1;
        res_dx_r      <= '0;
        res_dy_r      <= '0;
        res_fw_r      <= '0;
        res_fh_r      <= '0;
      end
      OP_FIT_END: begin
        res_written_r <= 1'b0;
        res_empty_r   <= 1'b0;
        res_dx_r      <= '0;
        res_dy_r      <= '0;
        res_fw_r      <= fit_wide_r ? bw1 : fit_q_r;
        res_fh_r      <= fit_wide_r ? fit_q_r : bh1;
      end
      OP_RES_EMIT: begin
        res_written_r <= 1'b1;
        res_empty_r   <= 1'b0;
        res_dx_r      <= lx[9:0];
        res_dy_r      <= ly[9:0];
        res_fw_r      <= '0;
        res_fh_r      <= '0;
      end
      default: ;
    endcase
  end

  // window scan and sums
  logic        rd_vld_r;
  logic        scx_wrap, scan_last;
  logic [15:0] pr_r, pr_g, pr_b;

  assign scx_wrap  = (CW+1)'(scx_r) + (CW+1)'(1) == (CW+1)'(x1_r);
  assign scan_last = scx_wrap && ((CW+1)'(scy_r) + (CW+1)'(1) == (CW+1)'(y1_r));
  assign pr_r      = 16'(rd_data_r[7:0])   * 16'(rd_data_r[31:24]);
  assign pr_g      = 16'(rd_data_r[15:8])  * 16'(rd_data_r[31:24]);
  assign pr_b      = 16'(rd_data_r[23:16]) * 16'(rd_data_r[31:24]);

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else        rd_vld_r <= rd_en;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SCAN_INIT) begin
      scx_r <= x0_r;
      scy_r <= y0_r;
    end else if (cmd.op == OP_SCAN) begin
      if (scx_wrap) begin
        scx_r <= x0_r;
        scy_r <= scy_r + CW'(1);
      end else begin
        scx_r <= scx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SCAN_INIT) begin
      acc_r_r <= '0;
      acc_g_r <= '0;
      acc_b_r <= '0;
      acc_a_r <= '0;
      n_r     <= '0;
    end else if (rd_vld_r) begin
      acc_r_r <= acc_r_r + CA_W'(pr_r);
      acc_g_r <= acc_g_r + CA_W'(pr_g);
      acc_b_r <= acc_b_r + CA_W'(pr_b);
      acc_a_r <= acc_a_r + AS_W'(rd_data_r[31:24]);
      n_r     <= n_r + NW'(1);
    end
  end

  // unpressed uses unity gain against the same 256 scale in the divisor
  logic [8:0] gain;
  assign gain = pressed_r ? dim_gain_r : UNITY_GAIN;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SHADE_PREP) begin
      prod_r_r <= NUM_W'(acc_r_r) * NUM_W'(gain);
      prod_g_r <= NUM_W'(acc_g_r) * NUM_W'(gain);
      prod_b_r <= NUM_W'(acc_b_r) * NUM_W'(gain);
    end
  end

  // output register
  logic        out_valid_r;
  logic [71:0] out_data_r;
  logic [1:0]  out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_PUSH) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUSH) begin
      out_data_r <= {2'b00, res_fh_r, res_fw_r, res_alpha_r, res_blue_r, res_green_r,
                     res_red_r, res_dy_r, res_dx_r};
      out_user_r <= {res_empty_r, res_written_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // status
  assign stat.cmd       = cmd_r;
  assign stat.ink_empty = ink_empty;
  assign stat.emit_skip = (fit_w_r == 9'd0) || (fit_h_r == 9'd0) || (col_r >= fit_w_r)
                          || (row_r >= fit_h_r) || ink_empty;
  assign stat.div_done  = div_done;
  assign stat.scan_last = scan_last;
  assign stat.asum_zero = (acc_a_r == '0);
  assign stat.out_free  = !out_valid_r || out_tready;

endmodule

FILE: design/afad_ctrl.sv
// Controller state machine: sequences load, fit and emit through the datapath.
module afad_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  afad_pkg::afad_stat_t stat,
  output afad_pkg::afad_cmd_t  cmd
);
  import afad_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE       = 16'h0001,
    S_DECODE     = 16'h0002,
    S_LOAD       = 16'h0004,
    S_RES_ZERO   = 16'h0008,
    S_FIT_EMPTY  = 16'h0010,
    S_FIT_PREP   = 16'h0020,
    S_DIV_GO     = 16'h0040,
    S_DIV_WAIT   = 16'h0080,
    S_FIT_END    = 16'h0100,
    S_WIN_FIX    = 16'h0200,
    S_SCAN_INIT  = 16'h0400,
    S_SCAN       = 16'h0800,
    S_DRAIN      = 16'h1000,
    S_SHADE_PREP = 16'h2000,
    S_RES_EMIT   = 16'h4000,
    S_OUT        = 16'h8000
  } state_t;

  state_t     state_r, state_nxt;
  afad_dsel_t dsel_r, dsel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dsel_r  <= DV_FIT;
    end else begin
      state_r <= state_nxt;
      dsel_r  <= dsel_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    dsel_nxt  = dsel_r;
    cmd.op    = OP_NONE;
    cmd.dsel  = dsel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.cmd == CMD_LOAD) begin
          state_nxt = S_LOAD;
        end else if (stat.cmd == CMD_FINISH) begin
          state_nxt = stat.ink_empty ? S_FIT_EMPTY : S_FIT_PREP;
        end else if (stat.cmd == CMD_EMIT && !stat.emit_skip) begin
          dsel_nxt  = DV_Y0;
          state_nxt = S_DIV_GO;
        end else begin
          state_nxt = S_RES_ZERO;
        end
      end
      S_LOAD: begin
        cmd.op    = OP_LOAD;
        state_nxt = S_RES_ZERO;
      end
      S_RES_ZERO: begin
        cmd.op    = OP_RES_ZERO;
        state_nxt = S_OUT;
      end
      S_FIT_EMPTY: begin
        cmd.op    = OP_FIT_EMPTY;
        state_nxt = S_OUT;
      end
      S_FIT_PREP: begin
        cmd.op    = OP_FIT_PREP;
        dsel_nxt  = DV_FIT;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.op    = OP_DIV_START;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.op = OP_DIV_STORE;
          // advance to the next quotient of the sequence
          case (dsel_r)
            DV_FIT: state_nxt = S_FIT_END;
            DV_Y0:  begin dsel_nxt = DV_Y1; state_nxt = S_DIV_GO; end
            DV_Y1:  begin dsel_nxt = DV_X0; state_nxt = S_DIV_GO; end
            DV_X0:  begin dsel_nxt = DV_X1; state_nxt = S_DIV_GO; end
            DV_X1:  state_nxt = S_WIN_FIX;
            DV_R:   begin dsel_nxt = DV_G; state_nxt = S_DIV_GO; end
            DV_G:   begin dsel_nxt = DV_B; state_nxt = S_DIV_GO; end
            DV_B:   begin dsel_nxt = DV_A; state_nxt = S_DIV_GO; end
            DV_A:   state_nxt = S_RES_EMIT;
            default: state_nxt = S_RES_ZERO;
          endcase
        end
      end
      S_FIT_END: begin
        cmd.op    = OP_FIT_END;
        state_nxt = S_OUT;
      end
      S_WIN_FIX: begin
        cmd.op    = OP_WIN_FIX;
        state_nxt = S_SCAN_INIT;
      end
      S_SCAN_INIT: begin
        cmd.op    = OP_SCAN_INIT;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // let the last read beat reach the sums
        state_nxt = S_SHADE_PREP;
      end
      S_SHADE_PREP: begin
        if (stat.asum_zero) begin
          cmd.op    = OP_RES_ZERO;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_SHADE_PREP;
          dsel_nxt  = DV_R;
          state_nxt = S_DIV_GO;
        end
      end
      S_RES_EMIT: begin
        cmd.op    = OP_RES_EMIT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op    = OP_PUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: design/alpha_fit_area_downscale.sv
// Top level of the alpha-fit area downscaler: controller and datapath.
//
// Loads one CELL_SIZE x CELL_SIZE RGBA cell (command 0), fits its ink box into the
// destination box (command 1) and emits one area-averaged destination pixel per
// command 2; every accepted beat returns exactly one result beat. One item is worked
// on at a time. A finish on a non-empty cell makes one run of the bit-serial divider,
// whose numerator is NUM_W = clog2(CELL_SIZE^2 + 1) + 25 bits wide (40 at CELL_SIZE
// 128). An emit that writes makes four divider runs to place the window, reads the
// pixel store one pixel per cycle, and makes four more runs for the colour and alpha.
// An emit outside the fitted rectangle or without a fit skips the divider; one whose
// window alpha sum is zero stops after the scan. No clearing pass is needed after
// reset. A result waiting at the output holds the block before its next input beat
// only while it is still untaken.
module alpha_fit_area_downscale #(
  parameter int CELL_SIZE = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // src_x, src_y, in_red, in_green, in_blue, in_alpha, out_col, out_row
  input  logic [63:0] in_tdata,
  // command
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // dest_x, dest_y, red, green, blue, alpha, fit_width, fit_height, zero pad
  output logic [71:0] out_tdata,
  // written, cell_empty
  output logic [1:0]  out_tuser
);
  import afad_pkg::*;

  afad_cmd_t  cmd;
  afad_stat_t stat;

  afad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  afad_datapath #(
    .CELL_SIZE(CELL_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the alpha-fit area downscaler: directed table, then random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import afad_pkg::*;

  localparam int CELL      = 128;
  localparam int CYC_LIMIT = 3000000;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic       written;
    logic [9:0] dest_x;
    logic [9:0] dest_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [8:0] fit_w;
    logic [8:0] fit_h;
    logic       empty;
  } pix_res_t;

  typedef struct {
    logic [1:0] cmd;
    logic [6:0] x;
    logic [6:0] y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic [8:0] col;
    logic [8:0] row;
    bit         typed;
    pix_res_t   res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [8:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;

  alpha_fit_area_downscale u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block's state and registers
  logic [8:0] m_box_x = BOX_X_RST, m_box_y = BOX_Y_RST, m_box_w = BOX_W_RST, m_box_h = BOX_H_RST;
  logic       m_pressed = 1'b0;
  logic [8:0] m_gain = DIM_GAIN_RST;
  logic [31:0] cell_px [CELL*CELL];
  bit          cell_wr [CELL*CELL];
  int ink_x0 = CELL, ink_y0 = CELL, ink_x1 = 0, ink_y1 = 0;
  int fit_w = 0, fit_h = 0;

  pix_res_t pending_px[$];
  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  int  rx_hold = 0;

  function automatic void src_window(input int col, input int row,
                                     output int x0, output int x1, output int y0, output int y1);
    int sw, sh;
    sw = ink_x1 - ink_x0;
    sh = ink_y1 - ink_y0;
    y0 = sh * row / fit_h;
    y1 = sh * (row + 1) / fit_h;
    if (y1 < y0 + 1) y1 = y0 + 1;
    x0 = sw * col / fit_w;
    x1 = sw * (col + 1) / fit_w;
    if (x1 < x0 + 1) x1 = x0 + 1;
  endfunction

  function automatic logic [7:0] shade_chan(longint unsigned acc, longint unsigned asum);
    longint unsigned v;
    if (m_pressed) v = (acc * m_gain) / (asum * 256);
    else v = acc / asum;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic bit ink_valid();
    return ink_x1 > ink_x0 && ink_y1 > ink_y0;
  endfunction

  function automatic pix_res_t predict_pixel(logic [1:0] cmd, logic [6:0] x, logic [6:0] y,
      logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
      logic [8:0] col, logic [8:0] row);
    pix_res_t o;
    longint unsigned sw, sh, bw, bh, ow, oh, acc_r, acc_g, acc_b, acc_a, n;
    int x0, x1, y0, y1, px, py, left, top;
    logic [31:0] w;
    o = '0;
    case (cmd)
      CMD_LOAD: begin
        cell_px[y*CELL + x] = {a, b, g, r};
        cell_wr[y*CELL + x] = 1'b1;
        if (a != 0) begin
          if (x < ink_x0) ink_x0 = x;
          if (y < ink_y0) ink_y0 = y;
          if (x + 1 > ink_x1) ink_x1 = x + 1;
          if (y + 1 > ink_y1) ink_y1 = y + 1;
        end
      end
      CMD_FINISH: begin
        if (!ink_valid()) begin
          fit_w = 0;
          fit_h = 0;
          o.empty = 1'b1;
        end else begin
          sw = ink_x1 - ink_x0;
          sh = ink_y1 - ink_y0;
          bw = m_box_w;
          bh = m_box_h;
          if (bw * sh <= bh * sw) begin
            ow = bw;
            oh = (2 * sh * bw + sw) / (2 * sw);
          end else begin
            oh = bh;
            ow = (2 * sw * bh + sh) / (2 * sh);
          end
          if (ow < 1) ow = 1;
          if (oh < 1) oh = 1;
          fit_w = int'(ow & 'h1FF);
          fit_h = int'(oh & 'h1FF);
          o.fit_w = 9'(fit_w);
          o.fit_h = 9'(fit_h);
        end
      end
      CMD_EMIT: begin
        if (fit_w != 0 && fit_h != 0 && col < fit_w && row < fit_h && ink_valid()) begin
          src_window(col, row, x0, x1, y0, y1);
          acc_r = 0; acc_g = 0; acc_b = 0; acc_a = 0; n = 0;
          for (int sy = y0; sy < y1; sy++)
            for (int sx = x0; sx < x1; sx++) begin
              px = ink_x0 + sx;
              py = ink_y0 + sy;
              if (px < CELL && py < CELL) begin
                w = cell_px[py*CELL + px];
                acc_r += w[7:0] * w[31:24];
                acc_g += w[15:8] * w[31:24];
                acc_b += w[23:16] * w[31:24];
                acc_a += w[31:24];
                n++;
              end
            end
          if (n != 0 && acc_a != 0) begin
            left = m_box_x + ((m_box_w >= fit_w) ? (m_box_w - fit_w) / 2 : 0);
            top  = m_box_y + ((m_box_h >= fit_h) ? (m_box_h - fit_h) / 2 : 0);
            o.written = 1'b1;
            o.dest_x = 10'((left + col) & 'h3FF);
            o.dest_y = 10'((top + row) & 'h3FF);
            o.red   = shade_chan(acc_r, acc_a);
            o.green = shade_chan(acc_g, acc_a);
            o.blue  = shade_chan(acc_b, acc_a);
            o.alpha = 8'((acc_a / n) & 'hFF);
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Drive one input beat, holding until the block takes it
  task automatic send_beat(logic [1:0] cmd, logic [6:0] x, logic [6:0] y,
      logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
      logic [8:0] col, logic [8:0] row, bit typed = 1'b0, pix_res_t typed_res = '0);
    pix_res_t p;
    p = predict_pixel(cmd, x, y, r, g, b, a, col, row);
    pending_px.push_back(typed ? typed_res : p);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {row, col, a, b, g, r, y, x};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_regs(logic [8:0] bx, logic [8:0] by, logic [8:0] bw, logic [8:0] bh,
                            logic pr, logic [8:0] gn);
    logic [8:0] vals [6];
    vals = '{bx, by, bw, bh, {8'd0, pr}, gn};
    // drop valid before waiting so the last beat is not taken twice
    in_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= i[2:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_box_x = bx; m_box_y = by; m_box_w = bw; m_box_h = bh; m_pressed = pr; m_gain = gn;
  endtask

  // Emit, first loading any pixel of the window not yet written
  task automatic emit_pixel(logic [8:0] col, logic [8:0] row);
    int x0, x1, y0, y1, px, py;
    if (fit_w != 0 && fit_h != 0 && col < fit_w && row < fit_h && ink_valid()) begin
      src_window(col, row, x0, x1, y0, y1);
      for (int sy = y0; sy < y1; sy++)
        for (int sx = x0; sx < x1; sx++) begin
          px = ink_x0 + sx;
          py = ink_y0 + sy;
          if (px < CELL && py < CELL && !cell_wr[py*CELL + px])
            send_beat(CMD_LOAD, px, py, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        end
    end
    send_beat(CMD_EMIT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              col, row);
  endtask

  task automatic random_item();
    int k;
    logic [7:0] a;
    k = $urandom_range(0, 99);
    if (k < 35) begin
      a = ($urandom_range(0, 3) == 0) ? 8'd0 : $urandom;
      send_beat(CMD_LOAD, $urandom_range(0, 15), $urandom_range(0, 15), $urandom, $urandom,
                $urandom, a, $urandom, $urandom);
    end else if (k < 45) begin
      send_beat(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom, 8'd0,
                $urandom, $urandom);
    end else if (k < 55) begin
      send_beat(CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    end else if (k < 92) begin
      emit_pixel($urandom_range(0, (fit_w > 0) ? fit_w - 1 : 3),
                 $urandom_range(0, (fit_h > 0) ? fit_h - 1 : 3));
    end else if (k < 97) begin
      emit_pixel($urandom, $urandom);
    end else begin
      send_beat(CMD_UNKNOWN, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    end
  endtask

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result side: random stalls and comparison with the oldest expectation
  always @(posedge clk) begin
    pix_res_t e, act;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      act.written = out_tuser[0];
      act.dest_x  = out_tdata[9:0];
      act.dest_y  = out_tdata[19:10];
      act.red     = out_tdata[27:20];
      act.green   = out_tdata[35:28];
      act.blue    = out_tdata[43:36];
      act.alpha   = out_tdata[51:44];
      act.fit_w   = out_tdata[60:52];
      act.fit_h   = out_tdata[69:61];
      act.empty   = out_tuser[1];
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $realtime, act);
        errors++;
      end else begin
        e = pending_px.pop_front();
        check_field("written", e.written, act.written);
        check_field("dest_x", e.dest_x, act.dest_x);
        check_field("dest_y", e.dest_y, act.dest_y);
        check_field("red", e.red, act.red);
        check_field("green", e.green, act.green);
        check_field("blue", e.blue, act.blue);
        check_field("alpha", e.alpha, act.alpha);
        check_field("fit_width", e.fit_w, act.fit_w);
        check_field("fit_height", e.fit_h, act.fit_h);
        check_field("cell_empty", e.empty, act.empty);
      end
    end
    if (quiet || !rst_n) begin
      out_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      rx_hold <= $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYC_LIMIT) begin
      $display("alpha_fit_area_downscale test failed");
      $finish;
    end
  end

  function automatic dir_row_t mk(logic [1:0] cmd, int x, int y, int r, int g, int b, int a,
                                  int col, int row, bit typed, pix_res_t res);
    dir_row_t d;
    d = '{cmd, x, y, r, g, b, a, col, row, typed, res};
    return d;
  endfunction

  initial begin
    dir_row_t dir_tab[$];
    pix_res_t z, e;
    z = '0;
    e = '0; e.empty = 1'b1;
    dir_tab.push_back(mk(CMD_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 1, e));
    dir_tab.push_back(mk(CMD_EMIT, 0, 0, 0, 0, 0, 0, 0, 0, 1, z));
    dir_tab.push_back(mk(CMD_UNKNOWN, 127, 127, 255, 255, 255, 255, 511, 511, 1, z));
    dir_tab.push_back(mk(CMD_LOAD, 0, 0, 255, 255, 255, 255, 0, 0, 1, z));
    dir_tab.push_back(mk(CMD_LOAD, 127, 127, 0, 0, 0, 0, 511, 511, 1, z));
    dir_tab.push_back(mk(CMD_LOAD, 1, 0, 255, 255, 255, 0, 0, 0, 1, z));
    dir_tab.push_back(mk(CMD_LOAD, 0, 1, 0, 0, 0, 128, 0, 0, 1, z));
    dir_tab.push_back(mk(CMD_LOAD, 1, 1, 10, 20, 30, 200, 0, 0, 1, z));
    e = '0; e.fit_w = 9'd38; e.fit_h = 9'd38;
    dir_tab.push_back(mk(CMD_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 1, e));
    e = '0; e.written = 1'b1; e.dest_x = 10'd13; e.dest_y = 10'd16;
    e.red = 8'd255; e.green = 8'd255; e.blue = 8'd255; e.alpha = 8'd255;
    dir_tab.push_back(mk(CMD_EMIT, 0, 0, 0, 0, 0, 0, 0, 0, 1, e));
    dir_tab.push_back(mk(CMD_EMIT, 0, 0, 0, 0, 0, 0, 37, 37, 0, z));
    dir_tab.push_back(mk(CMD_EMIT, 0, 0, 0, 0, 0, 0, 38, 0, 1, z));
    // window on a zero-alpha pixel
    dir_tab.push_back(mk(CMD_EMIT, 0, 0, 0, 0, 0, 0, 20, 0, 1, z));
    dir_tab.push_back(mk(CMD_EMIT, 0, 0, 0, 0, 0, 0, 0, 37, 0, z));
    dir_tab.push_back(mk(CMD_EMIT, 0, 0, 0, 0, 0, 0, 511, 511, 1, z));
    dir_tab.push_back(mk(CMD_EMIT, 0, 0, 0, 0, 0, 0, 19, 19, 0, z));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_beat(dir_tab[i].cmd, dir_tab[i].x, dir_tab[i].y, dir_tab[i].r, dir_tab[i].g,
                dir_tab[i].b, dir_tab[i].a, dir_tab[i].col, dir_tab[i].row,
                dir_tab[i].typed, dir_tab[i].res);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_regs(9'd0, 9'd0, 9'd1, 9'd1, 1'b0, 9'd0);
        1: write_regs(9'd511, 9'd511, 9'd511, 9'd511, 1'b1, UNITY_GAIN);
        2: write_regs(9'd100, 9'd200, 9'd7, 9'd50, 1'b1, 9'd0);
        3: write_regs(9'd300, 9'd20, 9'd0, 9'd9, 1'b1, DIM_GAIN_RST);
        4: write_regs(9'd5, 9'd5, 9'd64, 9'd3, 1'b0, UNITY_GAIN);
        default: write_regs($urandom, $urandom, $urandom_range(1, 80), $urandom_range(1, 80),
                            1'b1, $urandom_range(0, 256));
      endcase
      if (ph == 7) quiet = 1'b1;
      send_beat(CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
      repeat (110) random_item();
    end

    @(posedge clk);
    in_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("alpha_fit_area_downscale test passed");
    else $display("alpha_fit_area_downscale test failed");
    $finish;
  end

endmodule

FILE: sim.f
design/afad_pkg.sv
design/afad_div.sv
design/afad_datapath.sv
design/afad_ctrl.sv
design/alpha_fit_area_downscale.sv
tb/tb_top.sv
